FILE: hw/rtl/bmm_pkg.sv
// Shared constants, types and helpers for the banked memory map.
package bmm_pkg;

  // Bus operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Redraw request codes
  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_CELL   = 2'd1;
  localparam logic [1:0] RD_SCREEN = 2'd2;
  localparam logic [1:0] RD_BORDER = 2'd3;

  // I/O register addresses
  localparam logic [15:0] ADDR_VIDEO_CTRL = 16'hD018;
  localparam logic [15:0] ADDR_BORDER     = 16'hD020;
  localparam logic [15:0] ADDR_BACKGROUND = 16'hD021;
  localparam logic [15:0] ADDR_KEY_COL    = 16'hDC00;
  localparam logic [15:0] ADDR_KEY_ROW    = 16'hDC01;

  // Region tags on the top address bits
  localparam logic [3:0] NIB_IO          = 4'hD;
  localparam logic [5:0] COLOR_PAGE      = 6'b110110;  // D800-DBFF
  localparam logic [5:0] SCREEN_PAGE     = 6'b000001;  // 0400-07FF
  localparam logic [9:0] SCREEN_CELLS    = 10'd1000;

  localparam logic [7:0] COLOR_OR_MASK   = 8'hF0;
  localparam logic [7:0] SPACE_CODE      = 8'h20;
  localparam logic [7:0] ALT_SPACE_CODE  = 8'd96;
  localparam logic [7:0] RAM0_RESET      = 8'hEF;
  localparam logic [7:0] RAM1_RESET      = 8'h07;
  localparam logic [2:0] BANK_RESET      = 3'd7;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Active-low row byte for the columns enabled (low) in col_sel
  function automatic logic [7:0] key_rows(input logic [63:0] keys, input logic [7:0] col_sel);
    logic [7:0] acc;
    acc = '0;
    for (int c = 0; c < 8; c++) begin
      if (!col_sel[c]) acc = acc | keys[8*c +: 8];
    end
    return ~acc;
  endfunction

endpackage

FILE: hw/rtl/bmm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/banked_memory_map_with_io.sv
// Top level: banked RAM/ROM memory map with video and keyboard registers.
//
// One bus access (read, write or ROM-image load) enters on the in_ channel
// and gives exactly one word on the out_ channel: the byte read (zero for
// non-reads) and a redraw request (none, one cell, whole screen, border).
// In the accept cycle every memory is read; in the execute state the
// registered data is checked, written back and the result word is loaded
// into the output register. The main RAM is read and then written back,
// so a new access is not taken until the previous one leaves the execute state.
// out_valid is registered: it rises with the output register load that
// ends the execute state, which a held out_stall can delay.
// After rst, a clearing pass over all 65536 main RAM addresses writes the
// reset image into main RAM (bytes 0 and 1 get EF and 07) and zeros into
// color RAM; in_stall stays high meanwhile. ROM images hold garbage until loaded.
// When the receiver holds out_stall, the waiting result stays in the
// output register; one more access may be accepted, and it then waits in
// the execute state (with in_stall high) until the output register frees.
module banked_memory_map_with_io (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [63:0] keys_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [1:0]  redraw_kind,
  output logic [9:0]  redraw_cell
);

  bmm_pkg::state_t state, state_next;

  logic [15:0] clr_cnt;
  logic [2:0]  bank;            // shadow of RAM byte 1, bits 0..2
  logic [7:0]  video_mem_ctrl;
  logic [3:0]  border_color;
  logic [3:0]  background_color;
  logic [7:0]  key_column_select;

  // captured access
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [63:0] keys;

  logic accept, exec_fire, clearing;

  // memory ports
  logic        ram_we, ram_re, col_we, bas_we, ker_we, chr_we;
  logic [15:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_q, col_q, bas_q, ker_q, chr_q;
  logic [9:0]  col_waddr;
  logic [7:0]  col_wdata;

  // result
  logic [7:0] res_data;
  logic [1:0] res_kind;
  logic [9:0] res_cell;

  // --- control ---
  always_comb begin
    state_next = state;
    unique case (state)
      bmm_pkg::S_CLEAR: if (clr_cnt == 16'hFFFF) state_next = bmm_pkg::S_IDLE;
      bmm_pkg::S_IDLE:  if (in_valid) state_next = bmm_pkg::S_EXEC;
      bmm_pkg::S_EXEC:  if (!out_valid || !out_stall) state_next = bmm_pkg::S_IDLE;
      default:          state_next = bmm_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    clearing  = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      bmm_pkg::S_CLEAR: clearing = 1'b1;
      bmm_pkg::S_IDLE:  in_stall = 1'b0;
      bmm_pkg::S_EXEC:  exec_fire = !out_valid || !out_stall;
      default:          in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bmm_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= opcode;
      addr  <= address;
      wdata <= write_data;
      keys  <= keys_down;
    end
  end

  // --- read issue ---
  // A write to color RAM in I/O mode needs the screen byte at 0400+offset
  // instead of the RAM byte under the I/O area.
  always_comb begin
    ram_raddr = address;
    if (opcode == bmm_pkg::OP_WRITE && address[15:12] == bmm_pkg::NIB_IO &&
        bank[1:0] != 2'b00 && address[15:10] == bmm_pkg::COLOR_PAGE)
      ram_raddr = {bmm_pkg::SCREEN_PAGE, address[9:0]};
  end
  assign ram_re = accept;

  // --- execute ---
  logic is_io_nib, ram_mode, ram_changed, col_changed, in_color, in_screen;
  assign is_io_nib   = addr[15:12] == bmm_pkg::NIB_IO;
  assign ram_mode    = !is_io_nib || bank[1:0] == 2'b00;
  assign ram_changed = ram_q != wdata;
  assign col_changed = col_q != wdata;
  assign in_color    = addr[15:10] == bmm_pkg::COLOR_PAGE;
  assign in_screen   = addr[15:10] == bmm_pkg::SCREEN_PAGE && addr[9:0] < bmm_pkg::SCREEN_CELLS;

  logic [7:0] io_data;
  always_comb begin
    io_data = '0;
    if (in_color)                           io_data = col_q | bmm_pkg::COLOR_OR_MASK;
    else if (addr == bmm_pkg::ADDR_KEY_ROW) io_data = bmm_pkg::key_rows(keys, key_column_select);
    else if (addr == bmm_pkg::ADDR_VIDEO_CTRL) io_data = video_mem_ctrl;
    else if (addr == bmm_pkg::ADDR_BORDER)     io_data = {4'd0, border_color};
    else if (addr == bmm_pkg::ADDR_BACKGROUND) io_data = {4'd0, background_color};
    else if (addr == bmm_pkg::ADDR_KEY_COL)    io_data = key_column_select;
  end

  logic ex_ram_we, ex_col_we;
  always_comb begin
    res_data  = '0;
    res_kind  = bmm_pkg::RD_NONE;
    res_cell  = '0;
    ex_ram_we = 1'b0;
    ex_col_we = 1'b0;
    bas_we    = 1'b0;
    ker_we    = 1'b0;
    chr_we    = 1'b0;
    case (op)
      bmm_pkg::OP_READ: begin
        if (addr[15:13] == 3'b101) begin
          res_data = (bank[1:0] == 2'b11) ? bas_q : ram_q;
        end else if (addr[15:13] == 3'b111) begin
          res_data = bank[1] ? ker_q : ram_q;
        end else if (is_io_nib) begin
          if (bank[1:0] == 2'b00) res_data = ram_q;
          else if (!bank[2])      res_data = chr_q;
          else                    res_data = io_data;
        end else begin
          res_data = ram_q;
        end
      end
      bmm_pkg::OP_WRITE: begin
        if (ram_mode) begin
          if (ram_changed) begin
            ex_ram_we = 1'b1;
            if (in_screen) begin
              res_kind = bmm_pkg::RD_CELL;
              res_cell = addr[9:0];
            end
          end
        end else if (addr == bmm_pkg::ADDR_VIDEO_CTRL ||
                     addr == bmm_pkg::ADDR_BACKGROUND) begin
          res_kind = bmm_pkg::RD_SCREEN;
        end else if (addr == bmm_pkg::ADDR_BORDER) begin
          res_kind = bmm_pkg::RD_BORDER;
        end else if (in_color && col_changed) begin
          ex_col_we = 1'b1;
          if (ram_q != bmm_pkg::SPACE_CODE && ram_q != bmm_pkg::ALT_SPACE_CODE) begin
            res_kind = bmm_pkg::RD_CELL;
            res_cell = addr[9:0];
          end
        end
      end
      bmm_pkg::OP_LOAD: begin
        bas_we = exec_fire && addr[15:13] == 3'b101;
        chr_we = exec_fire && is_io_nib;
        ker_we = exec_fire && addr[15:13] == 3'b111;
      end
      default: res_data = '0;
    endcase
  end

  // I/O registers and bank shadow
  always_ff @(posedge clk) begin
    if (rst) begin
      bank              <= bmm_pkg::BANK_RESET;
      video_mem_ctrl    <= '0;
      border_color      <= '0;
      background_color  <= '0;
      key_column_select <= '0;
    end else if (exec_fire && op == bmm_pkg::OP_WRITE) begin
      if (ram_mode) begin
        if (addr == 16'd1) bank <= wdata[2:0];
      end else begin
        if (addr == bmm_pkg::ADDR_VIDEO_CTRL) video_mem_ctrl    <= wdata;
        if (addr == bmm_pkg::ADDR_BORDER)     border_color      <= wdata[3:0];
        if (addr == bmm_pkg::ADDR_BACKGROUND) background_color  <= wdata[3:0];
        if (addr == bmm_pkg::ADDR_KEY_COL)    key_column_select <= wdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      read_data   <= res_data;
      redraw_kind <= res_kind;
      redraw_cell <= res_cell;
    end
  end

  // --- memory write muxes (clearing pass or execute) ---
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = (clr_cnt == 16'd0) ? bmm_pkg::RAM0_RESET :
                  (clr_cnt == 16'd1) ? bmm_pkg::RAM1_RESET : 8'd0;
      col_we    = clr_cnt[15:10] == 6'd0;
      col_waddr = clr_cnt[9:0];
      col_wdata = '0;
    end else begin
      ram_we    = exec_fire && ex_ram_we;
      ram_waddr = addr;
      ram_wdata = wdata;
      col_we    = exec_fire && ex_col_we;
      col_waddr = addr[9:0];
      col_wdata = wdata;
    end
  end

  bmm_ram #(.WIDTH(8), .DEPTH(65536)) u_main_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_q)
  );

  bmm_ram #(.WIDTH(8), .DEPTH(1024)) u_color_ram (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .re(accept), .raddr(address[9:0]), .rdata(col_q)
  );

  bmm_ram #(.WIDTH(8), .DEPTH(8192)) u_bas_img (
    .clk(clk), .we(bas_we), .waddr(addr[12:0]), .wdata(wdata),
    .re(accept), .raddr(address[12:0]), .rdata(bas_q)
  );

  bmm_ram #(.WIDTH(8), .DEPTH(8192)) u_system_rom (
    .clk(clk), .we(ker_we), .waddr(addr[12:0]), .wdata(wdata),
    .re(accept), .raddr(address[12:0]), .rdata(ker_q)
  );

  bmm_ram #(.WIDTH(8), .DEPTH(4096)) u_char_rom (
    .clk(clk), .we(chr_we), .waddr(addr[11:0]), .wdata(wdata),
    .re(accept), .raddr(address[11:0]), .rdata(chr_q)
  );

endmodule

FILE: sim/banked_memory_map_with_io_test.sv
// Self-checking testbench for the banked memory map: directed table, then random bus accesses.
`timescale 1ns / 1ps

module banked_memory_map_with_io_test;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [15:0] SCREEN_BASE   = 16'h0400;
  localparam logic [15:0] SCREEN_END    = 16'h07E8;
  localparam logic [15:0] COLOR_BASE    = 16'hD800;
  localparam logic [15:0] BASIC_BASE    = 16'hA000;
  localparam logic [15:0] UPPER_RAM     = 16'hC000;
  localparam logic [15:0] IO_BASE       = 16'hD000;
  localparam logic [15:0] SYS_BASE      = 16'hE000;
  localparam logic [15:0] BANK_BYTE     = 16'h0001;
  localparam logic [63:0] ALL_KEYS      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          RANDOM_ITEMS  = 920;
  localparam int          QUIET_ITEMS   = 100;
  localparam int          WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [9:0] cell_ofs;
  } bus_word_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wd;
    logic [63:0] keys;
    bit          typed;
    bus_word_t   want;
  } bus_case_t;

  localparam int NUM_OPENING = 28;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [63:0] keys_down;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic [1:0]  redraw_kind;
  logic [9:0]  redraw_cell;

  banked_memory_map_with_io u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .address     (address),
    .write_data  (write_data),
    .keys_down   (keys_down),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .redraw_kind (redraw_kind),
    .redraw_cell (redraw_cell)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow state of the memory map
  logic [7:0] main_mem  [0:65535];
  logic [7:0] color_mem [0:1023];
  logic [7:0] basic_img [0:8191];
  logic [7:0] sys_rom   [0:8191];
  logic [7:0] char_rom  [0:4095];
  bit         basic_set [0:8191];
  bit         sys_set   [0:8191];
  bit         char_set  [0:4095];
  logic [7:0] vid_ctrl;
  logic [3:0] border_q;
  logic [3:0] backgr_q;
  logic [7:0] col_sel;

  bus_word_t  pending_words [$];
  int         mismatch_count;
  int         idle_cycles;
  int         stall_left;
  int         calm_left;
  bit         quiet_tail;

  bus_case_t opening_cases [0:NUM_OPENING-1] = '{
    '{bmm_pkg::OP_READ,  16'h0000, 8'h00, 64'h0, 1'b1, '{8'hEF, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'h0001, 8'h00, 64'h0, 1'b1, '{8'h07, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_LOAD,  16'hE000, 8'hA5, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_LOAD,  16'hFFFF, 8'h5A, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_LOAD,  16'hA000, 8'hC3, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_LOAD,  16'hDFFF, 8'h3C, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_LOAD,  16'h9FFF, 8'h77, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hE000, 8'h00, 64'h0, 1'b1, '{8'hA5, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hFFFF, 8'h00, 64'h0, 1'b1, '{8'h5A, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hA000, 8'h00, 64'h0, 1'b1, '{8'hC3, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hD020, 8'hFF, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_BORDER, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hD020, 8'h00, 64'h0, 1'b1, '{8'h0F, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hD018, 8'h15, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_SCREEN, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hD021, 8'h3C, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_SCREEN, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hDC00, 8'hFE, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hDC01, 8'h00, ALL_KEYS, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hDC01, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b0,
      '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'h0400, 8'h41, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_CELL, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'h07E7, 8'hFF, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_CELL, 10'd999}},
    '{bmm_pkg::OP_WRITE, 16'hD800, 8'h07, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_CELL, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hDBFF, 8'h0F, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_CELL, 10'd1023}},
    '{bmm_pkg::OP_WRITE, 16'h0401, 8'h20, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_CELL, 10'd1}},
    '{bmm_pkg::OP_WRITE, 16'hD801, 8'h05, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'h0001, 8'h03, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_READ,  16'hDFFF, 8'h00, 64'h0, 1'b1, '{8'h3C, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'h0001, 8'h04, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{bmm_pkg::OP_WRITE, 16'hD020, 8'h09, 64'h0, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}},
    '{OP_UNUSED, 16'hFFFF, 8'hFF, ALL_KEYS, 1'b1, '{8'h00, bmm_pkg::RD_NONE, 10'd0}}
  };

  // Active-low row byte: rows of keys down in columns whose select bit is low
  function automatic logic [7:0] row_byte(input logic [63:0] keys);
    logic [7:0] acc;
    acc = '0;
    for (int n = 0; n < 64; n++)
      if (keys[n] && !col_sel[n / 8]) acc[n % 8] = 1'b1;
    return ~acc;
  endfunction

  function automatic bus_word_t apply_access(input logic [1:0] op, input logic [15:0] a,
                                             input logic [7:0] v, input logic [63:0] keys);
    bus_word_t  r;
    logic [2:0] b;
    logic [9:0] off;
    r = '0;
    b = main_mem[1][2:0];
    off = a[9:0];
    case (op)
      bmm_pkg::OP_READ: begin
        if (a < BASIC_BASE || (a >= UPPER_RAM && a < IO_BASE)) r.data = main_mem[a];
        else if (a < UPPER_RAM)
          r.data = (b[1:0] == 2'b11) ? basic_img[a - BASIC_BASE] : main_mem[a];
        else if (a >= SYS_BASE) r.data = b[1] ? sys_rom[a[12:0]] : main_mem[a];
        else if (b[1:0] == 2'b00) r.data = main_mem[a];
        else if (!b[2]) r.data = char_rom[a[11:0]];
        else if (a[15:10] == COLOR_BASE[15:10]) r.data = color_mem[off] | 8'hF0;
        else if (a == bmm_pkg::ADDR_KEY_ROW) r.data = row_byte(keys);
        else if (a == bmm_pkg::ADDR_VIDEO_CTRL) r.data = vid_ctrl;
        else if (a == bmm_pkg::ADDR_BORDER) r.data = {4'h0, border_q};
        else if (a == bmm_pkg::ADDR_BACKGROUND) r.data = {4'h0, backgr_q};
        else if (a == bmm_pkg::ADDR_KEY_COL) r.data = col_sel;
      end
      bmm_pkg::OP_WRITE: begin
        if (a < IO_BASE || a >= SYS_BASE || b[1:0] == 2'b00) begin
          if (main_mem[a] != v) begin
            main_mem[a] = v;
            if (a >= SCREEN_BASE && a < SCREEN_END) begin
              r.kind = bmm_pkg::RD_CELL;
              r.cell_ofs = 10'(a - SCREEN_BASE);
            end
          end
        end else if (a == bmm_pkg::ADDR_VIDEO_CTRL) begin
          vid_ctrl = v;
          r.kind = bmm_pkg::RD_SCREEN;
        end else if (a == bmm_pkg::ADDR_BORDER) begin
          border_q = v[3:0];
          r.kind = bmm_pkg::RD_BORDER;
        end else if (a == bmm_pkg::ADDR_BACKGROUND) begin
          backgr_q = v[3:0];
          r.kind = bmm_pkg::RD_SCREEN;
        end else if (a[15:10] == COLOR_BASE[15:10]) begin
          if (color_mem[off] != v) begin
            color_mem[off] = v;
            // blank characters need no repaint when only their color changes
            if (main_mem[SCREEN_BASE + off] != bmm_pkg::SPACE_CODE &&
                main_mem[SCREEN_BASE + off] != bmm_pkg::ALT_SPACE_CODE) begin
              r.kind = bmm_pkg::RD_CELL;
              r.cell_ofs = off;
            end
          end
        end else if (a == bmm_pkg::ADDR_KEY_COL) begin
          col_sel = v;
        end
      end
      bmm_pkg::OP_LOAD: begin
        if (a >= BASIC_BASE && a < UPPER_RAM) begin
          basic_img[a - BASIC_BASE] = v;
          basic_set[a - BASIC_BASE] = 1'b1;
        end else if (a >= IO_BASE && a < SYS_BASE) begin
          char_rom[a[11:0]] = v;
          char_set[a[11:0]] = 1'b1;
        end else if (a >= SYS_BASE) begin
          sys_rom[a[12:0]] = v;
          sys_set[a[12:0]] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when a read here would see a ROM byte that was never loaded
  function automatic bit blank_rom_read(input logic [15:0] a);
    logic [2:0] b;
    b = main_mem[1][2:0];
    if (a >= BASIC_BASE && a < UPPER_RAM && b[1:0] == 2'b11) return !basic_set[a - BASIC_BASE];
    if (a >= SYS_BASE && b[1]) return !sys_set[a[12:0]];
    if (a >= IO_BASE && a < SYS_BASE && b[1:0] != 2'b00 && !b[2]) return !char_set[a[11:0]];
    return 1'b0;
  endfunction

  function automatic logic [15:0] pick_address();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return 16'($urandom);
    if (sel < 38) return SCREEN_BASE + 16'($urandom_range(0, 1023));
    if (sel < 53) return COLOR_BASE + 16'($urandom_range(0, 1023));
    if (sel < 65) begin
      case ($urandom_range(0, 5))
        0: return bmm_pkg::ADDR_VIDEO_CTRL;
        1: return bmm_pkg::ADDR_BORDER;
        2: return bmm_pkg::ADDR_BACKGROUND;
        3: return bmm_pkg::ADDR_KEY_COL;
        4: return bmm_pkg::ADDR_KEY_ROW;
        default: return IO_BASE + 16'($urandom_range(0, 255));
      endcase
    end
    if (sel < 71) return BANK_BYTE;
    if (sel < 85) begin
      // small windows at both ends of each ROM so loads and reads meet
      case ($urandom_range(0, 5))
        0: return BASIC_BASE + 16'($urandom_range(0, 63));
        1: return 16'hBFC0 + 16'($urandom_range(0, 63));
        2: return SYS_BASE + 16'($urandom_range(0, 63));
        3: return 16'hFFC0 + 16'($urandom_range(0, 63));
        4: return IO_BASE + 16'($urandom_range(0, 63));
        default: return 16'hDFC0 + 16'($urandom_range(0, 63));
      endcase
    end
    return ($urandom_range(0, 1) ? UPPER_RAM : 16'h0000) + 16'($urandom_range(0, 255));
  endfunction

  task automatic issue_access(input logic [1:0] op, input logic [15:0] a, input logic [7:0] v,
                              input logic [63:0] keys, input bit typed, input bus_word_t want);
    bus_word_t got;
    opcode     <= op;
    address    <= a;
    write_data <= v;
    keys_down  <= keys;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = apply_access(op, a, v, keys);
    pending_words.push_back(typed ? want : got);
  endtask

  task automatic maybe_pause(input int idx);
    if (quiet_tail || ((idx / 50) % 3 == 2)) return;
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0]  op;
    logic [15:0] a;
    logic [15:0] recent;
    logic [7:0]  v;
    logic [63:0] keys;
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = bmm_pkg::OP_READ;
    address    = '0;
    write_data = '0;
    keys_down  = '0;
    quiet_tail = 1'b0;
    recent     = '0;
    mismatch_count = 0;
    for (int i = 0; i < 65536; i++) main_mem[i] = 8'h00;
    for (int i = 0; i < 1024; i++) color_mem[i] = 8'h00;
    main_mem[0] = bmm_pkg::RAM0_RESET;
    main_mem[1] = bmm_pkg::RAM1_RESET;
    vid_ctrl = '0;
    border_q = '0;
    backgr_q = '0;
    col_sel  = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_OPENING; i++) begin
      maybe_pause(i);
      issue_access(opening_cases[i].op, opening_cases[i].addr, opening_cases[i].wd,
                   opening_cases[i].keys, opening_cases[i].typed, opening_cases[i].want);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_tail = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i == RANDOM_ITEMS / 2) drain_results();
      maybe_pause(i);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:       op = bmm_pkg::OP_READ;
        8, 9, 10, 11, 12, 13, 14, 15: op = bmm_pkg::OP_WRITE;
        16, 17, 18:                   op = bmm_pkg::OP_LOAD;
        default:                      op = OP_UNUSED;
      endcase
      a = ($urandom_range(0, 3) == 0) ? recent : pick_address();
      recent = a;
      case ($urandom_range(0, 9))
        0:       v = bmm_pkg::SPACE_CODE;
        1:       v = bmm_pkg::ALT_SPACE_CODE;
        default: v = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       keys = {$urandom, $urandom};
        1:       keys = 64'h1 << $urandom_range(0, 63);
        2:       keys = ~(64'h1 << $urandom_range(0, 63));
        default: keys = $urandom_range(0, 1) ? ALL_KEYS : 64'h0;
      endcase
      // never read a ROM byte before it holds data; load it instead
      if (op == bmm_pkg::OP_READ && blank_rom_read(a)) op = bmm_pkg::OP_LOAD;
      issue_access(op, a, v, keys, 1'b0, '0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("banked_memory_map_with_io_test: PASS");
    end else begin
      $display("banked_memory_map_with_io_test: FAIL");
    end
    $finish;
  end

  // Receiver stall: random bursts separated by calm stretches, none at the tail
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 13);
      else calm_left <= $urandom_range(0, 40);
    end
  end

  // Result word check
  always @(posedge clk) begin : result_check
    bus_word_t exp_word;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_words.size() == 0) begin
        $display("%0t ns: unexpected word: expected none, actual data=%h kind=%0d cell=%0d",
                 $time, read_data, redraw_kind, redraw_cell);
        mismatch_count++;
      end else begin
        exp_word = pending_words.pop_front();
        if (read_data !== exp_word.data) begin
          $display("%0t ns: read_data: expected %h, actual %h", $time, exp_word.data, read_data);
          mismatch_count++;
        end
        if (redraw_kind !== exp_word.kind) begin
          $display("%0t ns: redraw_kind: expected %0d, actual %0d",
                   $time, exp_word.kind, redraw_kind);
          mismatch_count++;
        end
        if (redraw_cell !== exp_word.cell_ofs) begin
          $display("%0t ns: redraw_cell: expected %0d, actual %0d",
                   $time, exp_word.cell_ofs, redraw_cell);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: limit covers the RAM clearing pass after reset
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("banked_memory_map_with_io_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
